FILE: rtl/core/tbp_pkg.sv
// tbp_pkg: shared widths, types, codes and helper functions for the
// tournament branch predictor. No dependencies.
package tbp_pkg;

    // table geometry
    localparam int GHIST_W = 13;
    localparam int LHIST_W = 11;
    localparam int PIDX_W  = 11;
    localparam int CNT_W   = 2;
    localparam int CFG_W   = 4;
    localparam int CIDX_W  = 2;
    localparam int PC_W    = 32;
    localparam int GDEPTH  = 1 << GHIST_W;
    localparam int LDEPTH  = 1 << LHIST_W;
    localparam int PDEPTH  = 1 << PIDX_W;
    localparam int MASK_W  = 1 << CFG_W;

    // chooser counter codes that select the global side
    localparam logic [CNT_W-1:0] SG = 2'd0;
    localparam logic [CNT_W-1:0] WG = 2'd1;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_GHIST_BITS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_LHIST_BITS = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_PIDX_BITS  = 2'd2;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] GHIST_BITS_RST = 4'd9;
    localparam logic [CFG_W-1:0] LHIST_BITS_RST = 4'd10;
    localparam logic [CFG_W-1:0] PIDX_BITS_RST  = 4'd10;

    // one queued item
    typedef struct packed {
        logic              train;
        logic              taken;
        logic [PIDX_W-1:0] pidx;
    } t_item;

    // clamped configuration
    typedef struct packed {
        logic [CFG_W-1:0] ghist_bits;
        logic [CFG_W-1:0] lhist_bits;
    } t_cfg;

    // status from the back part to the front part
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_status;

    // zero acts as one, above max acts as max
    function automatic logic [CFG_W-1:0] clamp_bits(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] maxb);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) r = CFG_W'(1);
        else if (v > maxb) r = maxb;
        return r;
    endfunction

    // mask of the low n bits
    function automatic logic [MASK_W-1:0] low_mask(input logic [CFG_W-1:0] n);
        logic [MASK_W-1:0] m;
        for (int i = 0; i < MASK_W; i++) begin
            m[i] = (CFG_W'(i) < n);
        end
        return m;
    endfunction

    // 2-bit saturating counter step
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c, input logic up);
        logic [CNT_W-1:0] r;
        r = c;
        if (up) begin
            if (c != '1) r = c + CNT_W'(1);
        end else begin
            if (c != '0) r = c - CNT_W'(1);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/tbp_front.sv
// tbp_front: configuration registers and the two-entry item queue that
// feeds the back part. Depends on tbp_pkg.
module tbp_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         i_opcode,
    input  logic [tbp_pkg::PC_W-1:0]     i_pc,
    input  logic                         i_outcome,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tbp_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [tbp_pkg::CFG_W-1:0]    i_cfg_data,
    input  tbp_pkg::t_back_status        i_status,
    output logic                         o_item_valid,
    output tbp_pkg::t_item               o_item,
    output tbp_pkg::t_cfg                o_cfg
);

    logic [tbp_pkg::CFG_W-1:0] r_ghist_bits;
    logic [tbp_pkg::CFG_W-1:0] r_lhist_bits;
    logic [tbp_pkg::CFG_W-1:0] r_pidx_bits;

    tbp_pkg::t_item r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    logic           in_beat;
    logic           out_beat;
    tbp_pkg::t_item new_item;
    logic [tbp_pkg::MASK_W-1:0] pmask;

    assign o_cfg_ready = 1'b1;

    // config writes, clamped on entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ghist_bits <= tbp_pkg::GHIST_BITS_RST;
            r_lhist_bits <= tbp_pkg::LHIST_BITS_RST;
            r_pidx_bits  <= tbp_pkg::PIDX_BITS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tbp_pkg::CFG_GHIST_BITS: r_ghist_bits <= tbp_pkg::clamp_bits(i_cfg_data,
                    tbp_pkg::CFG_W'(tbp_pkg::GHIST_W));
                tbp_pkg::CFG_LHIST_BITS: r_lhist_bits <= tbp_pkg::clamp_bits(i_cfg_data,
                    tbp_pkg::CFG_W'(tbp_pkg::LHIST_W));
                tbp_pkg::CFG_PIDX_BITS:  r_pidx_bits  <= tbp_pkg::clamp_bits(i_cfg_data,
                    tbp_pkg::CFG_W'(tbp_pkg::PIDX_W));
                default: ;
            endcase
        end
    end

    assign o_cfg.ghist_bits = r_ghist_bits;
    assign o_cfg.lhist_bits = r_lhist_bits;

    // classify the incoming beat: keep only the local history slot
    assign pmask          = tbp_pkg::low_mask(r_pidx_bits);
    assign new_item.train = i_opcode;
    assign new_item.taken = i_outcome;
    assign new_item.pidx  = i_pc[tbp_pkg::PIDX_W-1:0] & pmask[tbp_pkg::PIDX_W-1:0];

    assign full     = (r_cnt == 2'd2) || i_status.clearing;
    assign in_beat  = push && !full;
    assign out_beat = i_status.pop && (r_cnt != 2'd0);

    // item queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (in_beat) r_wp <= ~r_wp;
            if (out_beat) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(in_beat) - 2'(out_beat);
        end
    end

    // item queue storage
    always_ff @(posedge i_clk) begin
        if (in_beat) r_q[r_wp] <= new_item;
    end

    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

endmodule

FILE: rtl/core/tbp_back.sv
// tbp_back: table sequencer, tables, global history and the result queue.
// Depends on tbp_pkg.
module tbp_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_valid,
    input  tbp_pkg::t_item        i_item,
    input  tbp_pkg::t_cfg         i_cfg,
    output tbp_pkg::t_back_status o_status,
    input  logic                  pop,
    output logic                  empty,
    output logic                  o_prediction
);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_RESOLVE} t_state;

    t_state                         r_state;
    tbp_pkg::t_item                 r_item;
    logic [tbp_pkg::GHIST_W-1:0]    r_ghist;
    logic [tbp_pkg::GHIST_W-1:0]    r_gidx;
    logic [tbp_pkg::LHIST_W-1:0]    r_lidx;
    logic [tbp_pkg::LHIST_W-1:0]    r_lhist;
    logic [tbp_pkg::GHIST_W-1:0]    r_clr_addr;

    // tables
    logic [tbp_pkg::CNT_W-1:0]   r_gc_mem [tbp_pkg::GDEPTH];
    logic [tbp_pkg::CNT_W-1:0]   r_ch_mem [tbp_pkg::GDEPTH];
    logic [tbp_pkg::LHIST_W-1:0] r_lh_mem [tbp_pkg::PDEPTH];
    logic [tbp_pkg::CNT_W-1:0]   r_lc_mem [tbp_pkg::LDEPTH];
    logic [tbp_pkg::CNT_W-1:0]   r_gc_rd;
    logic [tbp_pkg::CNT_W-1:0]   r_ch_rd;
    logic [tbp_pkg::LHIST_W-1:0] r_lh_rd;
    logic [tbp_pkg::CNT_W-1:0]   r_lc_rd;

    // table port controls
    logic                        g_re, g_we;
    logic [tbp_pkg::GHIST_W-1:0] g_raddr, g_waddr;
    logic [tbp_pkg::CNT_W-1:0]   gc_wdata, ch_wdata;
    logic                        lh_re, lh_we;
    logic [tbp_pkg::PIDX_W-1:0]  lh_raddr, lh_waddr;
    logic [tbp_pkg::LHIST_W-1:0] lh_wdata;
    logic                        lc_re, lc_we;
    logic [tbp_pkg::LHIST_W-1:0] lc_raddr, lc_waddr;
    logic [tbp_pkg::CNT_W-1:0]   lc_wdata;

    logic [tbp_pkg::MASK_W-1:0]  gmask, lmask;
    logic [tbp_pkg::GHIST_W-1:0] gidx;
    logic [tbp_pkg::LHIST_W-1:0] lidx;
    logic                        start;
    logic                        gpred, lpred, use_global, pred;

    // result queue
    logic       r_res [2];
    logic       r_res_wp;
    logic       r_res_rp;
    logic [1:0] r_res_cnt;
    logic       res_push;
    logic       res_pop;

    // index formation
    assign gmask = tbp_pkg::low_mask(i_cfg.ghist_bits);
    assign lmask = tbp_pkg::low_mask(i_cfg.lhist_bits);
    assign gidx  = r_ghist & gmask[tbp_pkg::GHIST_W-1:0];
    assign lidx  = r_lh_rd & lmask[tbp_pkg::LHIST_W-1:0];

    // prediction from the registered table reads
    assign gpred      = r_gc_rd[1];
    assign lpred      = r_lc_rd[1];
    assign use_global = (r_ch_rd == tbp_pkg::SG) || (r_ch_rd == tbp_pkg::WG);
    assign pred       = use_global ? gpred : lpred;

    assign start = (r_state == S_IDLE) && i_item_valid && (r_res_cnt != 2'd2);

    // table port steering per sequencer step
    always_comb begin
        g_re     = 1'b0;
        g_we     = 1'b0;
        g_raddr  = gidx;
        g_waddr  = r_gidx;
        gc_wdata = tbp_pkg::bump(r_gc_rd, r_item.taken);
        ch_wdata = (gpred != lpred) ? tbp_pkg::bump(r_ch_rd, gpred != r_item.taken) : r_ch_rd;
        lh_re    = 1'b0;
        lh_we    = 1'b0;
        lh_raddr = i_item.pidx;
        lh_waddr = r_item.pidx;
        lh_wdata = {r_lhist[tbp_pkg::LHIST_W-2:0], r_item.taken};
        lc_re    = 1'b0;
        lc_we    = 1'b0;
        lc_raddr = lidx;
        lc_waddr = r_lidx;
        lc_wdata = tbp_pkg::bump(r_lc_rd, r_item.taken);
        res_push = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                g_we     = 1'b1;
                g_waddr  = r_clr_addr;
                gc_wdata = '0;
                ch_wdata = tbp_pkg::SG;
                lh_we    = 1'b1;
                lh_waddr = r_clr_addr[tbp_pkg::PIDX_W-1:0];
                lh_wdata = '0;
                lc_we    = 1'b1;
                lc_waddr = r_clr_addr[tbp_pkg::LHIST_W-1:0];
                lc_wdata = '0;
            end
            S_IDLE: begin
                g_re  = start;
                lh_re = start;
            end
            S_LOOK: begin
                lc_re = 1'b1;
            end
            S_RESOLVE: begin
                g_we     = r_item.train;
                lh_we    = r_item.train;
                lc_we    = r_item.train;
                res_push = 1'b1;
            end
            default: ;
        endcase
    end

    // global counter and chooser tables
    always_ff @(posedge i_clk) begin
        if (g_we) begin
            r_gc_mem[g_waddr] <= gc_wdata;
            r_ch_mem[g_waddr] <= ch_wdata;
        end
        if (g_re) begin
            r_gc_rd <= r_gc_mem[g_raddr];
            r_ch_rd <= r_ch_mem[g_raddr];
        end
    end

    // local history table
    always_ff @(posedge i_clk) begin
        if (lh_we) r_lh_mem[lh_waddr] <= lh_wdata;
        if (lh_re) r_lh_rd <= r_lh_mem[lh_raddr];
    end

    // local counter table
    always_ff @(posedge i_clk) begin
        if (lc_we) r_lc_mem[lc_waddr] <= lc_wdata;
        if (lc_re) r_lc_rd <= r_lc_mem[lc_raddr];
    end

    // sequencer: clearing sweep, then three steps per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_ghist    <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + tbp_pkg::GHIST_W'(1);
                    if (r_clr_addr == '1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_item  <= i_item;
                        r_gidx  <= gidx;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_lidx  <= lidx;
                    r_lhist <= r_lh_rd;
                    r_state <= S_RESOLVE;
                end
                S_RESOLVE: begin
                    if (r_item.train) begin
                        r_ghist <= {r_ghist[tbp_pkg::GHIST_W-2:0], r_item.taken};
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_status.pop      = start;
    assign o_status.clearing = (r_state == S_CLEAR);

    // result queue pointers
    assign res_pop = pop && (r_res_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wp  <= 1'b0;
            r_res_rp  <= 1'b0;
            r_res_cnt <= 2'd0;
        end else begin
            if (res_push) r_res_wp <= ~r_res_wp;
            if (res_pop) r_res_rp <= ~r_res_rp;
            r_res_cnt <= r_res_cnt + 2'(res_push) - 2'(res_pop);
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (res_push) r_res[r_res_wp] <= pred;
    end

    assign empty        = (r_res_cnt == 2'd0);
    assign o_prediction = r_res[r_res_rp];

endmodule

FILE: rtl/core/tournament_branch_predictor.sv
// tournament_branch_predictor: top level, front queue plus back sequencer.
// Depends on tbp_pkg, tbp_front and tbp_back.
//
//   channel   direction  handshake             beat contents
//   item in   input      push / full           i_opcode, i_pc, i_outcome
//   result    output     empty / pop           o_prediction
//   config    input      i_cfg_valid / ready   i_cfg_index, i_cfg_data
//
// Each item passes the back sequencer in order: global table and local history
// read, local counter read, then resolve and table write-back on one port per table.
// After reset a clearing sweep zeroes all tables; full stays high meanwhile,
// config writes are taken as ever.
// Two-entry queues on both sides let input and result beats stall on their own.
module tournament_branch_predictor (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         i_opcode,
    input  logic [tbp_pkg::PC_W-1:0]     i_pc,
    input  logic                         i_outcome,
    output logic                         empty,
    input  logic                         pop,
    output logic                         o_prediction,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tbp_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [tbp_pkg::CFG_W-1:0]    i_cfg_data
);

    tbp_pkg::t_back_status status;
    tbp_pkg::t_item        item;
    tbp_pkg::t_cfg         cfg;
    logic                  item_valid;

    // intake and configuration
    tbp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_opcode     (i_opcode),
        .i_pc         (i_pc),
        .i_outcome    (i_outcome),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_status     (status),
        .o_item_valid (item_valid),
        .o_item       (item),
        .o_cfg        (cfg)
    );

    // tables and sequencing
    tbp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .i_cfg        (cfg),
        .o_status     (status),
        .pop          (pop),
        .empty        (empty),
        .o_prediction (o_prediction)
    );

endmodule
